>>> rtl/gspc_pkg.sv
// ----------------------------------------------------------------------------
// gspc_pkg: shared types, constants and stage functions
// Stage layout, status codes, register indexes and the per-stage arithmetic
// of the gas sensor concentration pipeline.
// ----------------------------------------------------------------------------
package gspc_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_VOLT_LOW   = 3'd1,
      STATUS_RES_BAD    = 3'd2,
      STATUS_SATURATED  = 3'd3,
      STATUS_SLOPE_ZERO = 3'd4
   } status_type;

   // csr register indexes
   typedef enum logic [2:0] {
      REG_VREF      = 3'd0,
      REG_CIRCUIT   = 3'd1,
      REG_LOAD      = 3'd2,
      REG_CLEAN_AIR = 3'd3,
      REG_SLOPE     = 3'd4,
      REG_OFFSET    = 3'd5,
      REG_MIN_VOUT  = 3'd6
   } reg_index_type;

   localparam int CSR_DATA_W = 20;
   localparam int CSR_INDEX_W = 3;

   // divider: 36-bit dividend, 16-bit divisor, two quotient bits a stage
   localparam int DIV_BITS = 36;
   localparam int DIV_PER_STAGE = 2;
   localparam int DIV_STAGES = DIV_BITS / DIV_PER_STAGE;
   // log2: one fraction bit (one squaring) a stage
   localparam int LOG_STAGES = 16;
   // exp2: sixteen square roots, two root bits a stage
   localparam int EXP_ITERS = 16;
   localparam int SQRT_BITS = 32;
   localparam int SQRT_PER_STAGE = 2;
   localparam int EXP_SUB = SQRT_BITS / SQRT_PER_STAGE;

   localparam int S_IN = 0;
   localparam int S_CHK = 1;
   localparam int DIV1_FIRST = 2;
   localparam int S_RS = DIV1_FIRST + DIV_STAGES;
   localparam int S_NORM = S_RS + 1;
   localparam int LOG_FIRST = S_NORM + 1;
   localparam int S_L2 = LOG_FIRST + LOG_STAGES;
   localparam int S_D = S_L2 + 1;
   localparam int DIV2_FIRST = S_D + 1;
   localparam int S_C = DIV2_FIRST + DIV_STAGES;
   localparam int S_Z = S_C + 1;
   localparam int EXP_FIRST = S_Z + 1;
   localparam int S_OUT = EXP_FIRST + EXP_ITERS * EXP_SUB;
   localparam int STAGES = S_OUT + 1;

   localparam logic signed [37:0] LOG10_2_Q16 = 38'sd19728;
   localparam logic signed [55:0] LOG2_10_Q16 = 56'sd217706;
   localparam logic signed [39:0] PPM_Q8_BIAS = 40'sd524288;
   localparam logic signed [39:0] Z_LIMIT = 40'sd2097152;

   typedef struct packed {
      status_type         status;
      logic               early;
      logic               slope_zero;
      logic               rs_sat;
      logic               ppm_sat;
      logic               ppm_zero;
      logic [15:0]        vout;
      logic [35:0]        num;
      logic [15:0]        rem;
      logic [15:0]        divisor;
      logic [35:0]        rs;
      logic [31:0]        ohms;
      logic [5:0]         rs_e;
      logic [31:0]        rs_m;
      logic [15:0]        rs_fr;
      logic [4:0]         r0_e;
      logic [31:0]        r0_m;
      logic [15:0]        r0_fr;
      logic signed [37:0] lprod;
      logic               neg;
      logic signed [55:0] yprod;
      logic [4:0]         n;
      logic [15:0]        f;
      logic [31:0]        r;
      logic [63:0]        sq_v;
      logic [63:0]        sq_root;
      logic [31:0]        ppm;
   } pipe_type;

   // index of the top set bit
   function automatic logic [5:0] msb36(input logic [35:0] x);
      logic [5:0] e;
      e = '0;
      for (int i = 0; i < 36; i++) begin
         if (x[i]) e = 6'(i);
      end
      return e;
   endfunction

   // restoring division, quotient bits shift into num
   function automatic pipe_type div_stage(input pipe_type p);
      pipe_type   q;
      logic [16:0] sh;
      q = p;
      for (int i = 0; i < DIV_PER_STAGE; i++) begin
         sh = {q.rem, q.num[35]};
         q.num = {q.num[34:0], 1'b0};
         if (sh >= {1'b0, q.divisor}) begin
            sh = sh - {1'b0, q.divisor};
            q.num[0] = 1'b1;
         end
         q.rem = sh[15:0];
      end
      return q;
   endfunction

   // one squaring of the Q1.31 mantissa gives one fraction bit
   function automatic pipe_type log_stage(input pipe_type p);
      pipe_type    q;
      logic [63:0] sa;
      logic [63:0] sb;
      logic [32:0] ta;
      logic [32:0] tb;
      q = p;
      sa = 64'(p.rs_m) * 64'(p.rs_m);
      sb = 64'(p.r0_m) * 64'(p.r0_m);
      ta = sa[63:31];
      tb = sb[63:31];
      q.rs_fr = {p.rs_fr[14:0], ta[32]};
      q.r0_fr = {p.r0_fr[14:0], tb[32]};
      q.rs_m = ta[32] ? ta[32:1] : ta[31:0];
      q.r0_m = tb[32] ? tb[32:1] : tb[31:0];
      return q;
   endfunction

   // part of one square root of r * 2^30, after the optional doubling
   function automatic pipe_type exp_stage(input pipe_type p, input logic [3:0] it,
                                          input logic [3:0] sub);
      pipe_type    q;
      logic [4:0]  j;
      logic [5:0]  sh;
      logic [63:0] bitv;
      q = p;
      if (sub == 4'd0) begin
         if (q.f[it]) q.r = {q.r[30:0], 1'b0};
         q.sq_v = {2'b0, q.r, 30'b0};
         q.sq_root = '0;
      end
      for (int i = 0; i < SQRT_PER_STAGE; i++) begin
         j = {sub, 1'b0} + 5'(i);
         sh = 6'd62 - {j, 1'b0};
         bitv = 64'd1 << sh;
         if (q.sq_v >= q.sq_root + bitv) begin
            q.sq_v = q.sq_v - (q.sq_root + bitv);
            q.sq_root = (q.sq_root >> 1) + bitv;
         end else begin
            q.sq_root = q.sq_root >> 1;
         end
      end
      if (sub == 4'(EXP_SUB - 1)) q.r = q.sq_root[31:0];
      return q;
   endfunction

endpackage

>>> rtl/gas_sensor_ppm_converter.sv
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter: metal-oxide sensor sample to ppm
// Converts raw converter samples of a sensor divider to resistance and a
// power-law gas concentration in fixed point, one item per clock while req_stall is low.
// ----------------------------------------------------------------------------
// One item enters every clock unless req_stall is high; the length (STAGES)
// is set by the exponent, sixteen chained integer square roots at two root
// bits a stage, after two 36-bit restoring dividers at two quotient bits a
// stage and a sixteen-stage log2 squaring chain. A stall on the result side
// freezes the whole pipeline and is passed straight back as req_stall. The
// registers must be written through the csr port only while no item is in
// flight; the block does not enforce this. Every stage reads them directly.
module gas_sensor_ppm_converter
   import gspc_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ADC_BITS-1:0]    req_adc_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_ppm_q8,
   output logic [31:0]            rsp_sensor_ohms,
   output logic [2:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PROD_W = ADC_BITS + 16;

   // configuration registers
   logic [15:0]        vref_mv_ff;
   logic [15:0]        circuit_mv_ff;
   logic [19:0]        load_ohms_ff;
   logic [19:0]        clean_air_ohms_ff;
   logic signed [15:0] slope_q12_ff;
   logic signed [15:0] offset_q12_ff;
   logic [15:0]        min_vout_mv_ff;

   pipe_type           stage_in [STAGES];
   pipe_type           stage_ff [STAGES];
   logic [STAGES-1:0]  valid_in;
   logic [STAGES-1:0]  valid_ff;
   logic               advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_mv_ff        <= 16'd3300;
         circuit_mv_ff     <= 16'd3300;
         load_ohms_ff      <= 20'd10000;
         clean_air_ohms_ff <= 20'd20000;
         slope_q12_ff      <= -16'sd1843;
         offset_q12_ff     <= 16'sd4915;
         min_vout_mv_ff    <= 16'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_VREF:      vref_mv_ff        <= csr_wdata[15:0];
            REG_CIRCUIT:   circuit_mv_ff     <= csr_wdata[15:0];
            REG_LOAD:      load_ohms_ff      <= csr_wdata;
            REG_CLEAN_AIR: clean_air_ohms_ff <= csr_wdata;
            REG_SLOPE:     slope_q12_ff      <= $signed(csr_wdata[15:0]);
            REG_OFFSET:    offset_q12_ff     <= $signed(csr_wdata[15:0]);
            REG_MIN_VOUT:  min_vout_mv_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // whole pipe holds while the result waits
   assign advance = !(valid_ff[S_OUT] && rsp_stall);
   assign req_stall = !advance;
   assign valid_in = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) stage_ff <= stage_in;
   end

   // sensor voltage: sample * vref / full scale
   always_comb begin
      pipe_type            p;
      logic [PROD_W-1:0]   vprod;
      p = '0;
      vprod = PROD_W'(req_adc_sample) * PROD_W'(vref_mv_ff);
      p.vout = 16'(vprod >> ADC_BITS);
      stage_in[S_IN] = p;
   end

   // range checks and divider set-up for load * (circuit - vout) / vout
   always_comb begin
      pipe_type p;
      p = stage_ff[S_IN];
      p.status = STATUS_OK;
      if (p.vout == 16'd0 || p.vout < min_vout_mv_ff) begin
         p.early = 1'b1;
         p.status = STATUS_VOLT_LOW;
      end else if (circuit_mv_ff <= p.vout) begin
         p.early = 1'b1;
         p.status = STATUS_RES_BAD;
      end
      p.num = 36'(load_ohms_ff) * 36'(circuit_mv_ff - p.vout);
      p.rem = '0;
      p.divisor = p.vout;
      stage_in[S_CHK] = p;
   end

   for (genvar k = DIV1_FIRST; k < DIV1_FIRST + DIV_STAGES; k++) begin : g_div1
      assign stage_in[k] = div_stage(stage_ff[k-1]);
   end

   // resistance, its saturation, and the exponents of rs and r0
   always_comb begin
      pipe_type    p;
      logic [19:0] r0;
      logic [5:0]  r0_e;
      p = stage_ff[S_RS-1];
      r0 = (clean_air_ohms_ff == 20'd0) ? 20'd1 : clean_air_ohms_ff;
      p.rs = p.num;
      if (!p.early && p.rs == 36'd0) begin
         p.early = 1'b1;
         p.status = STATUS_RES_BAD;
      end
      p.rs_sat = |p.rs[35:32];
      p.ohms = p.rs_sat ? '1 : p.rs[31:0];
      p.slope_zero = (slope_q12_ff == 16'sd0);
      p.rs_e = msb36(p.rs);
      r0_e = msb36(36'(r0));
      p.r0_e = r0_e[4:0];
      stage_in[S_RS] = p;
   end

   // normalise both values to Q1.31
   always_comb begin
      pipe_type    p;
      logic [19:0] r0;
      logic [63:0] wide;
      p = stage_ff[S_NORM-1];
      r0 = (clean_air_ohms_ff == 20'd0) ? 20'd1 : clean_air_ohms_ff;
      if (p.rs_e <= 6'd31) wide = {28'b0, p.rs} << (6'd31 - p.rs_e);
      else wide = {28'b0, p.rs} >> (p.rs_e - 6'd31);
      p.rs_m = wide[31:0];
      wide = {44'b0, r0} << (5'd31 - p.r0_e);
      p.r0_m = wide[31:0];
      p.rs_fr = '0;
      p.r0_fr = '0;
      stage_in[S_NORM] = p;
   end

   for (genvar k = LOG_FIRST; k < LOG_FIRST + LOG_STAGES; k++) begin : g_log
      assign stage_in[k] = log_stage(stage_ff[k-1]);
   end

   // log2(rs / r0) times log10(2)
   always_comb begin
      pipe_type           p;
      logic signed [22:0] l2;
      p = stage_ff[S_L2-1];
      l2 = $signed({1'b0, p.rs_e, p.rs_fr}) - $signed({2'b0, p.r0_e, p.r0_fr});
      p.lprod = 38'(l2) * LOG10_2_Q16;
      stage_in[S_L2] = p;
   end

   // d = lg - offset, set up |d| * 4096 / |slope|
   always_comb begin
      pipe_type           p;
      logic signed [37:0] adj;
      logic signed [23:0] off16;
      logic signed [23:0] d;
      logic [23:0]        mag;
      p = stage_ff[S_D-1];
      adj = p.lprod + (p.lprod[37] ? 38'sd65535 : 38'sd0);
      off16 = 24'(offset_q12_ff) * 24'sd16;
      d = 24'(adj >>> 16) - off16;
      mag = d[23] ? 24'(-d) : 24'(d);
      p.num = {mag, 12'b0};
      p.rem = '0;
      p.divisor = slope_q12_ff[15] ? 16'(~slope_q12_ff + 16'sd1) : 16'(slope_q12_ff);
      p.neg = d[23] ^ slope_q12_ff[15];
      stage_in[S_D] = p;
   end

   for (genvar k = DIV2_FIRST; k < DIV2_FIRST + DIV_STAGES; k++) begin : g_div2
      assign stage_in[k] = div_stage(stage_ff[k-1]);
   end

   // c back to signed, times log2(10)
   always_comb begin
      pipe_type           p;
      logic signed [36:0] c;
      p = stage_ff[S_C-1];
      c = p.neg ? -$signed({1'b0, p.num}) : $signed({1'b0, p.num});
      p.yprod = 56'(c) * LOG2_10_Q16;
      stage_in[S_C] = p;
   end

   // z = log2 of ppm_q8; split into shift and fraction
   always_comb begin
      pipe_type           p;
      logic signed [55:0] adj;
      logic signed [39:0] z;
      p = stage_ff[S_Z-1];
      adj = p.yprod + (p.yprod[55] ? 56'sd65535 : 56'sd0);
      z = 40'(adj >>> 16) + PPM_Q8_BIAS;
      p.ppm_zero = z[39];
      p.ppm_sat = !z[39] && (z >= Z_LIMIT);
      p.n = z[20:16];
      p.f = z[15:0];
      p.r = 32'h4000_0000;
      stage_in[S_Z] = p;
   end

   for (genvar it = 0; it < EXP_ITERS; it++) begin : g_exp
      for (genvar s = 0; s < EXP_SUB; s++) begin : g_sub
         localparam int K = EXP_FIRST + it * EXP_SUB + s;
         assign stage_in[K] = exp_stage(stage_ff[K-1], 4'(it), 4'(s));
      end
   end

   // scale by 2^n and settle the status
   always_comb begin
      pipe_type    p;
      logic [63:0] wide;
      p = stage_ff[S_OUT-1];
      wide = ({32'b0, p.r} << p.n) >> 30;
      if (p.early) begin
         p.ppm = '0;
         p.ohms = '0;
      end else if (p.slope_zero) begin
         p.ppm = '0;
         p.status = STATUS_SLOPE_ZERO;
      end else begin
         if (p.ppm_sat) p.ppm = '1;
         else if (p.ppm_zero) p.ppm = '0;
         else p.ppm = wide[31:0];
         p.status = (p.rs_sat || p.ppm_sat) ? STATUS_SATURATED : STATUS_OK;
      end
      stage_in[S_OUT] = p;
   end

   assign rsp_valid = valid_ff[S_OUT];
   assign rsp_ppm_q8 = stage_ff[S_OUT].ppm;
   assign rsp_sensor_ohms = stage_ff[S_OUT].ohms;
   assign rsp_status = stage_ff[S_OUT].status;

`ifndef ASSERT_OFF
   // rejected samples carry no concentration and no resistance
   a_early_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_VOLT_LOW || rsp_status == STATUS_RES_BAD)
      |-> rsp_ppm_q8 == 32'd0 && rsp_sensor_ohms == 32'd0)
      else $error("rejected item with nonzero payload");

   // a zero slope gives no concentration
   a_slope_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_SLOPE_ZERO |-> rsp_ppm_q8 == 32'd0)
      else $error("slope zero item with concentration");

   // the exponent unit alone can never reach the saturation value
   a_ok_not_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_ppm_q8 != '1)
      else $error("saturated concentration with ok status");

   // a stalled result freezes every stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(valid_ff))
      else $error("pipeline moved under stall");
`endif

endmodule
